[rtl/core/aabbcr_pkg.sv]
// Shared types and constants of the AABB collision resolver.
package aabbcr_pkg;

    localparam logic KIND_START    = 1'b0;
    localparam logic KIND_OBSTACLE = 1'b1;

    localparam int              THR_WIDTH = 16;
    localparam logic [15:0]     THR_RESET = 16'd655;

    typedef logic [2:0] t_op_code;

    localparam t_op_code OP_NONE      = 3'd0;
    localparam t_op_code OP_START     = 3'd1;
    localparam t_op_code OP_EVAL      = 3'd2;
    localparam t_op_code OP_PUSH_X    = 3'd3;
    localparam t_op_code OP_PUSH_Y_DN = 3'd4;
    localparam t_op_code OP_PUSH_Y_UP = 3'd5;

    typedef struct packed {
        t_op_code code;
        logic     last;
        logic     ground_init;
    } t_op_ctrl;

endpackage

[rtl/core/aabbcr_fifo.sv]
// Small flip-flop queue with first-word fall-through read.
module aabbcr_fifo
    import aabbcr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == NW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> (!o_empty && r_count == $past(r_count) + 1'b1))
        else $error("push without pop did not grow the queue");

endmodule

[rtl/core/aabbcr_front.sv]
// Front end: accepts requests, tests overlap against the mover box, picks the push axis.
module aabbcr_front
    import aabbcr_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [THR_WIDTH-1:0]          i_cfg_wdata,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_kind,
    input  logic signed [COORD_WIDTH-1:0] i_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic                          i_is_static,
    input  logic                          i_was_grounded,
    input  logic                          i_last,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output t_op_ctrl                      o_ctrl,
    output logic [COORD_WIDTH-1:0]        o_val_a,
    output logic signed [COORD_WIDTH:0]   o_val_b
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = COORD_WIDTH + 1;

    logic [THR_WIDTH-1:0]   r_thr;
    logic signed [CW-1:0]   r_box_min_x, r_box_min_y, r_box_max_x, r_box_max_y;
    logic                   r_static;

    logic                   r_s1_valid;
    t_op_code               r_s1_code;
    logic                   r_s1_last;
    logic                   r_s1_gnd;
    logic signed [PW-1:0]   r_p0, r_p1, r_p2, r_p3;

    logic                   w_accept;
    logic                   w_overlap;
    logic signed [PW-1:0]   w_thr, w_mx, w_my;
    logic                   w_sel_r, w_sel_b;

    assign o_full   = r_s1_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_s1_valid && !i_q_full;

    assign w_overlap = (r_box_max_x > i_min_x) && (r_box_min_x < i_max_x) &&
                       (r_box_max_y > i_min_y) && (r_box_min_y < i_max_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_box_min_x <= '0;
            r_box_min_y <= '0;
            r_box_max_x <= '0;
            r_box_max_y <= '0;
            r_static    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s1_code   <= OP_NONE;
            r_s1_last   <= 1'b0;
            r_s1_gnd    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_last  <= i_last;
                if (i_kind == KIND_START) begin
                    r_box_min_x <= i_min_x;
                    r_box_min_y <= i_min_y;
                    r_box_max_x <= i_max_x;
                    r_box_max_y <= i_max_y;
                    r_static    <= i_is_static;
                    r_s1_code   <= OP_START;
                    r_s1_gnd    <= i_is_static && i_was_grounded;
                end else begin
                    r_s1_code <= (!r_static && w_overlap) ? OP_EVAL : OP_NONE;
                    r_s1_gnd  <= 1'b0;
                end
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_kind == KIND_START) begin
                r_p0 <= PW'(i_pos_x);
                r_p1 <= PW'(i_pos_y);
                r_p2 <= '0;
                r_p3 <= '0;
            end else begin
                r_p0 <= PW'(r_box_max_x) - PW'(i_min_x);
                r_p1 <= PW'(i_max_x) - PW'(r_box_min_x);
                r_p2 <= PW'(r_box_max_y) - PW'(i_min_y);
                r_p3 <= PW'(i_max_y) - PW'(r_box_min_y);
            end
        end
    end

    assign w_thr   = PW'($signed({1'b0, r_thr}));
    assign w_sel_r = r_p0 < r_p1;
    assign w_sel_b = r_p2 < r_p3;
    assign w_mx    = w_sel_r ? r_p0 : r_p1;
    assign w_my    = w_sel_b ? r_p2 : r_p3;

    always_comb begin
        o_ctrl.last        = r_s1_last;
        o_ctrl.ground_init = r_s1_gnd;
        o_ctrl.code        = r_s1_code;
        o_val_a            = r_p0[CW-1:0];
        o_val_b            = r_p1;
        case (r_s1_code)
            OP_EVAL: begin
                if ((w_mx < w_my) && (w_mx > w_thr)) begin
                    o_ctrl.code = OP_PUSH_X;
                    o_val_b     = w_sel_r ? -r_p0 : r_p1;
                end else if (!(w_mx < w_my) && (w_my > w_thr)) begin
                    o_ctrl.code = w_sel_b ? OP_PUSH_Y_DN : OP_PUSH_Y_UP;
                    o_val_b     = w_sel_b ? -r_p2 : r_p3;
                end else begin
                    o_ctrl.code = OP_NONE;
                end
            end
            default: begin
                o_ctrl.code = r_s1_code;
            end
        endcase
    end

    a_static_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_OBSTACLE && r_static) |=> (r_s1_code == OP_NONE))
        else $error("obstacle evaluated for a static mover");

endmodule

[rtl/core/aabbcr_back.sv]
// Back end: applies push-outs to the position accumulator and emits results.
module aabbcr_back
    import aabbcr_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  t_op_ctrl                      i_ctrl,
    input  logic [COORD_WIDTH-1:0]        i_val_a,
    input  logic signed [COORD_WIDTH:0]   i_val_b,
    output logic                          o_q_pop,
    input  logic                          i_out_full,
    output logic                          o_out_push,
    output logic [COORD_WIDTH-1:0]        o_pos_x,
    output logic [COORD_WIDTH-1:0]        o_pos_y,
    output logic                          o_cvx,
    output logic                          o_cvy,
    output logic                          o_gnd
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = COORD_WIDTH + 2;

    logic signed [CW-1:0] r_acc_x, r_acc_y, n_acc_x, n_acc_y;
    logic                 r_cvx, r_cvy, r_gnd, n_cvx, n_cvy, n_gnd;
    logic signed [CW-1:0] w_operand, w_sat;
    logic signed [SW-1:0] w_sum;
    logic                 w_in_range;

    assign o_q_pop    = !i_q_empty && (!i_ctrl.last || !i_out_full);
    assign o_out_push = o_q_pop && i_ctrl.last;

    assign w_operand  = (i_ctrl.code == OP_PUSH_X) ? r_acc_x : r_acc_y;
    assign w_sum      = SW'(w_operand) + SW'(i_val_b);
    assign w_in_range = (w_sum[SW-1] == w_sum[CW-1]) && (w_sum[CW] == w_sum[CW-1]);
    assign w_sat      = w_in_range ? w_sum[CW-1:0] :
                        (w_sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

    always_comb begin
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_cvx   = r_cvx;
        n_cvy   = r_cvy;
        n_gnd   = r_gnd;
        case (i_ctrl.code)
            OP_START: begin
                n_acc_x = i_val_a;
                n_acc_y = i_val_b[CW-1:0];
                n_cvx   = 1'b0;
                n_cvy   = 1'b0;
                n_gnd   = i_ctrl.ground_init;
            end
            OP_PUSH_X: begin
                n_acc_x = w_sat;
                n_cvx   = 1'b1;
            end
            OP_PUSH_Y_DN: begin
                n_acc_y = w_sat;
                n_cvy   = 1'b1;
                n_gnd   = 1'b1;
            end
            OP_PUSH_Y_UP: begin
                n_acc_y = w_sat;
                n_cvy   = 1'b1;
            end
            default: begin
                n_acc_x = r_acc_x;
            end
        endcase
    end

    assign o_pos_x = n_acc_x;
    assign o_pos_y = n_acc_y;
    assign o_cvx   = n_cvx;
    assign o_cvy   = n_cvy;
    assign o_gnd   = n_gnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_cvx   <= 1'b0;
            r_cvy   <= 1'b0;
            r_gnd   <= 1'b0;
        end else if (o_q_pop) begin
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_cvx   <= n_cvx;
            r_cvy   <= n_cvy;
            r_gnd   <= n_gnd;
        end
    end

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_ctrl.code == OP_START) |=> (!r_cvx && !r_cvy))
        else $error("start request left velocity clear flags set");

endmodule

[rtl/core/aabb_collision_resolver.sv]
// Top level of the AABB collision resolver: front end, request queue, back end, result queue.
//
// One request is taken per clock while full is low, start and obstacle alike, and the
// block keeps that pace for any run length. A request is registered in the front end with
// its overlap test and push amounts; its push axis is then selected combinationally as it
// enters the request queue, and the back end applies it through a single saturating
// adder on the position accumulator, which is the only feedback path. A result
// passes the front register, request queue and result queue on its way to the result
// ports, and waits in the result queue until popped. The request queue holds MID_DEPTH
// entries and the result queue OUT_DEPTH entries; full rises only once both the front
// register and the request queue are occupied. The threshold register may be written only
// while the block is idle.
module aabb_collision_resolver
    import aabbcr_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int MID_DEPTH   = 4,
    parameter int OUT_DEPTH   = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [THR_WIDTH-1:0]          i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_kind,
    input  logic signed [COORD_WIDTH-1:0] i_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic                          i_is_static,
    input  logic                          i_was_grounded,
    input  logic                          i_last,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_WIDTH-1:0] o_new_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_new_pos_y,
    output logic                          o_clear_vel_x,
    output logic                          o_clear_vel_y,
    output logic                          o_grounded
);

    localparam int CW = COORD_WIDTH;
    localparam int CTW = $bits(t_op_ctrl);
    localparam int MW = CTW + CW + CW + 1;
    localparam int OW = CW + CW + 3;

    logic                 w_mid_push, w_mid_full, w_mid_pop, w_mid_empty;
    t_op_ctrl             w_front_ctrl, w_back_ctrl;
    logic [CW-1:0]        w_front_a, w_back_a;
    logic signed [CW:0]   w_front_b, w_back_b;
    logic [MW-1:0]        w_mid_wdata, w_mid_rdata;

    logic                 w_out_push, w_out_full;
    logic [CW-1:0]        w_res_x, w_res_y;
    logic                 w_res_cvx, w_res_cvy, w_res_gnd;
    logic [OW-1:0]        w_out_wdata, w_out_rdata;

    aabbcr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .o_full         (full),
        .i_kind         (i_kind),
        .i_min_x        (i_min_x),
        .i_min_y        (i_min_y),
        .i_max_x        (i_max_x),
        .i_max_y        (i_max_y),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_is_static    (i_is_static),
        .i_was_grounded (i_was_grounded),
        .i_last         (i_last),
        .i_q_full       (w_mid_full),
        .o_q_push       (w_mid_push),
        .o_ctrl         (w_front_ctrl),
        .o_val_a        (w_front_a),
        .o_val_b        (w_front_b)
    );

    assign w_mid_wdata = {w_front_ctrl, w_front_a, w_front_b};

    aabbcr_fifo #(
        .WIDTH (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_wdata (w_mid_wdata),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_rdata (w_mid_rdata),
        .o_empty (w_mid_empty)
    );

    assign w_back_ctrl = t_op_ctrl'(w_mid_rdata[MW-1 -: CTW]);
    assign w_back_a    = w_mid_rdata[CW+CW : CW+1];
    assign w_back_b    = w_mid_rdata[CW:0];

    aabbcr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_mid_empty),
        .i_ctrl     (w_back_ctrl),
        .i_val_a    (w_back_a),
        .i_val_b    (w_back_b),
        .o_q_pop    (w_mid_pop),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_pos_x    (w_res_x),
        .o_pos_y    (w_res_y),
        .o_cvx      (w_res_cvx),
        .o_cvy      (w_res_cvy),
        .o_gnd      (w_res_gnd)
    );

    assign w_out_wdata = {w_res_x, w_res_y, w_res_cvx, w_res_cvy, w_res_gnd};

    aabbcr_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_wdata (w_out_wdata),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_rdata (w_out_rdata),
        .o_empty (empty)
    );

    assign o_new_pos_x   = w_out_rdata[OW-1 -: CW];
    assign o_new_pos_y   = w_out_rdata[CW+2:3];
    assign o_clear_vel_x = w_out_rdata[2];
    assign o_clear_vel_y = w_out_rdata[1];
    assign o_grounded    = w_out_rdata[0];

endmodule
